// File: design/lrc_pkg.sv
// Shared types, constants and codes for the LRU keyed result cache.
// Used by the top level, the scan unit and the port checker; no dependencies.
package lrc_pkg;

  // Storage geometry
  localparam int ENTRIES  = 16;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 31;
  localparam int CAP_W    = 5;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W   = $clog2(ENTRIES + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(16);

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_STORE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } lrc_state_t;

  // Input item
  typedef struct packed {
    logic [1:0]         mode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } lrc_in_t;

  // Result item
  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] data_out;
    logic               evicted;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] miss_count;
  } lrc_out_t;

  // Summary gathered by the entry scan
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  match_idx;
    logic [IDX_W-1:0]  match_rank;
    logic [FILL_W-1:0] fill;
    logic              oldest_found;
    logic [IDX_W-1:0]  oldest_idx;
    logic [IDX_W-1:0]  oldest_rank;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
  } lrc_scan_t;

endpackage

// File: design/lru_keyed_result_cache_unit.sv
// Top level of the LRU keyed result cache: entry storage, sequencer,
// counters and result register. Depends on lrc_pkg and lrc_scan.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one operation
//   (mode, key, value). It transfers when in_valid is high and in_stall low.
//   Result channel out_valid / out_stall / out_data returns exactly one
//   result per operation, in order, and transfers when out_valid is high
//   and out_stall low. Write capacity on cfg_valid / cfg_ready / cfg_data
//   while the block is idle; cfg_ready is always high.
//   Lookup and store pass through a start step, one scan step per entry in
//   the scan unit, which compares one key and one rank per cycle, and a
//   final step that writes back ranks and loads the result. Clear and the
//   unused mode skip the scan and go straight to the final step. in_stall
//   stays high from a transfer until the result is loaded, so one item is
//   in work at a time; a loaded result may wait in the output register
//   while the next item is taken.
//   When the receiver stalls, the result holds and the write-back waits
//   until the output register is free.
//   Reset empties all entries, zeroes both counters and sets capacity 16.
module lru_keyed_result_cache_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lrc_pkg::lrc_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lrc_pkg::lrc_out_t            out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lrc_pkg::CAP_W-1:0]    cfg_data
);

  localparam int ENTRIES = lrc_pkg::ENTRIES;
  localparam int IDX_W   = lrc_pkg::IDX_W;
  localparam int FILL_W  = lrc_pkg::FILL_W;
  localparam int COUNT_W = lrc_pkg::COUNT_W;

  // Entry storage
  logic [ENTRIES-1:0]              valid_r;
  logic [lrc_pkg::KEY_W-1:0]       key_r   [ENTRIES];
  logic [lrc_pkg::VALUE_W-1:0]     value_r [ENTRIES];
  logic [IDX_W-1:0]                rank_r  [ENTRIES];

  // Control and counters
  lrc_pkg::lrc_state_t             state_r, state_nxt;
  logic [IDX_W-1:0]                idx_r;
  lrc_pkg::lrc_in_t                op_r;
  logic [lrc_pkg::CAP_W-1:0]       capacity_r;
  logic [COUNT_W-1:0]              hits_r, hits_nxt;
  logic [COUNT_W-1:0]              misses_r, misses_nxt;
  logic                            out_valid_r;
  lrc_pkg::lrc_out_t               out_data_r, result;

  logic                            in_xfer;
  logic                            scan_start, scan_step, apply_fire;
  lrc_pkg::lrc_scan_t              scan;

  logic [FILL_W-1:0]               cap_eff;
  logic                            do_hit, do_promote, do_insert, do_evict, do_clear;
  logic [IDX_W-1:0]                ins_slot;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (state_r != lrc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Shared scan unit
  lrc_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .step      (scan_step),
    .idx       (idx_r),
    .ent_valid (valid_r[idx_r]),
    .ent_key   (key_r[idx_r]),
    .ent_rank  (rank_r[idx_r]),
    .key       (op_r.key),
    .summary   (scan)
  );

  // Sequencer: next state and step controls
  always_comb begin
    state_nxt  = state_r;
    scan_start = 1'b0;
    scan_step  = 1'b0;
    apply_fire = 1'b0;
    case (state_r)
      lrc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          scan_start = 1'b1;
          if ((in_data.mode == lrc_pkg::MODE_LOOKUP) ||
              (in_data.mode == lrc_pkg::MODE_STORE)) begin
            state_nxt = lrc_pkg::ST_SCAN;
          end else begin
            state_nxt = lrc_pkg::ST_APPLY;
          end
        end
      end
      lrc_pkg::ST_SCAN: begin
        scan_step = 1'b1;
        if (idx_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = lrc_pkg::ST_APPLY;
        end
      end
      lrc_pkg::ST_APPLY: begin
        if (!out_valid_r || !out_stall) begin
          apply_fire = 1'b1;
          state_nxt  = lrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lrc_pkg::ST_IDLE;
      end
    endcase
  end

  // Clamp the capacity to 1..ENTRIES
  always_comb begin
    if (capacity_r == '0) begin
      cap_eff = FILL_W'(1);
    end else if (32'(capacity_r) > 32'(ENTRIES)) begin
      cap_eff = FILL_W'(ENTRIES);
    end else begin
      cap_eff = FILL_W'(capacity_r);
    end
  end

  // Decide the operation outcome from the scan summary
  always_comb begin
    do_hit     = 1'b0;
    do_promote = 1'b0;
    do_insert  = 1'b0;
    do_evict   = 1'b0;
    do_clear   = 1'b0;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    ins_slot   = scan.free_idx;
    case (op_r.mode)
      lrc_pkg::MODE_LOOKUP: begin
        if (scan.found) begin
          do_hit     = 1'b1;
          do_promote = 1'b1;
          if (hits_r != lrc_pkg::COUNT_MAX) begin
            hits_nxt = hits_r + COUNT_W'(1);
          end
        end else if (misses_r != lrc_pkg::COUNT_MAX) begin
          misses_nxt = misses_r + COUNT_W'(1);
        end
      end
      lrc_pkg::MODE_STORE: begin
        if (scan.found) begin
          do_promote = 1'b1;
        end else begin
          do_insert = 1'b1;
          if (scan.fill >= cap_eff) begin
            do_evict = 1'b1;
            ins_slot = scan.oldest_idx;
          end
        end
      end
      lrc_pkg::MODE_CLEAR: begin
        do_clear   = 1'b1;
        hits_nxt   = '0;
        misses_nxt = '0;
      end
      default: begin
        do_hit = 1'b0;
      end
    endcase

    result.hit        = do_hit;
    result.data_out   = do_hit ? value_r[scan.match_idx] : '0;
    result.evicted    = do_evict;
    result.hit_count  = hits_nxt;
    result.miss_count = misses_nxt;
  end

  // Control registers, valid bits, counters and result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrc_pkg::ST_IDLE;
      idx_r       <= '0;
      capacity_r  <= lrc_pkg::CAP_RESET;
      hits_r      <= '0;
      misses_r    <= '0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (scan_start) begin
        idx_r <= '0;
      end else if (scan_step) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
      if (apply_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (apply_fire) begin
        hits_r   <= hits_nxt;
        misses_r <= misses_nxt;
        if (do_clear) begin
          valid_r <= '0;
        end else if (do_insert) begin
          valid_r[ins_slot] <= 1'b1;
        end
      end
    end
  end

  // Payload: latched operation, result, keys, values and ranks
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r <= in_data;
    end
    if (apply_fire) begin
      out_data_r <= result;
      if (do_promote) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && (IDX_W'(i) != scan.match_idx) &&
              (rank_r[i] < scan.match_rank)) begin
            rank_r[i] <= rank_r[i] + IDX_W'(1);
          end
        end
        rank_r[scan.match_idx] <= '0;
        if (op_r.mode == lrc_pkg::MODE_STORE) begin
          value_r[scan.match_idx] <= op_r.value;
        end
      end else if (do_insert) begin
        // Age every other valid entry, then place the new one as newest
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && (IDX_W'(i) != ins_slot)) begin
            rank_r[i] <= rank_r[i] + IDX_W'(1);
          end
        end
        rank_r[ins_slot]  <= '0;
        key_r[ins_slot]   <= op_r.key;
        value_r[ins_slot] <= op_r.value;
      end
    end
  end

endmodule

// File: design/lrc_scan.sv
// Entry scan unit: one key compare and one rank compare per cycle while step is high.
// Accumulates match, fill, oldest and first free slot; uses lrc_pkg.
module lrc_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       step,
  input  logic [lrc_pkg::IDX_W-1:0]  idx,
  input  logic                       ent_valid,
  input  logic [lrc_pkg::KEY_W-1:0]  ent_key,
  input  logic [lrc_pkg::IDX_W-1:0]  ent_rank,
  input  logic [lrc_pkg::KEY_W-1:0]  key,
  output lrc_pkg::lrc_scan_t         summary
);

  localparam int FILL_W = lrc_pkg::FILL_W;

  lrc_pkg::lrc_scan_t acc_r;
  lrc_pkg::lrc_scan_t acc_nxt;

  // Fold the current entry into the running summary
  always_comb begin
    acc_nxt = acc_r;
    if (start) begin
      acc_nxt              = '0;
    end else if (step) begin
      if (ent_valid) begin
        acc_nxt.fill = acc_r.fill + FILL_W'(1);
        if (!acc_r.oldest_found || (ent_rank > acc_r.oldest_rank)) begin
          acc_nxt.oldest_found = 1'b1;
          acc_nxt.oldest_idx   = idx;
          acc_nxt.oldest_rank  = ent_rank;
        end
        if (!acc_r.found && (ent_key == key)) begin
          acc_nxt.found      = 1'b1;
          acc_nxt.match_idx  = idx;
          acc_nxt.match_rank = ent_rank;
        end
      end else if (!acc_r.free_found) begin
        acc_nxt.free_found = 1'b1;
        acc_nxt.free_idx   = idx;
      end
    end
  end

  // Hold the summary between steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign summary = acc_r;

endmodule

// File: design/lrc_checker.sv
// Port-level checker for the LRU keyed result cache, bound to the top level.
// Sees the top-level ports only; uses lrc_pkg types.
module lrc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input lrc_pkg::lrc_in_t          in_data,
  input logic                      out_valid,
  input logic                      out_stall,
  input lrc_pkg::lrc_out_t         out_data,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [lrc_pkg::CAP_W-1:0] cfg_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Go busy right after an input transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // Never report a hit and an eviction together
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && out_data.evicted))
    else $error("hit and evicted both set");

  // Drive zero data on a miss
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.data_out == '0)
    else $error("nonzero data without a hit");

endmodule

bind lru_keyed_result_cache_unit lrc_checker u_lrc_checker (.*);

// File: bench/lru_keyed_result_cache_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for lru_keyed_result_cache_unit: directed and random lookup, store
// and clear traffic across capacity settings, checked against an in-bench LRU predictor.
// Depends on lrc_pkg and the cache RTL only.
module lru_keyed_result_cache_unit_tb;

  localparam int ENTRIES = lrc_pkg::ENTRIES;
  localparam int KEY_W   = lrc_pkg::KEY_W;
  localparam int VALUE_W = lrc_pkg::VALUE_W;
  localparam int COUNT_W = lrc_pkg::COUNT_W;
  localparam int CAP_W   = lrc_pkg::CAP_W;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int POOL_SIZE = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lrc_pkg::lrc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lrc_pkg::lrc_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  // Predicted cache contents
  logic               slot_valid [ENTRIES];
  logic [KEY_W-1:0]   slot_key   [ENTRIES];
  logic [VALUE_W-1:0] slot_value [ENTRIES];
  int                 slot_rank  [ENTRIES];
  logic [COUNT_W-1:0] hit_total;
  logic [COUNT_W-1:0] miss_total;
  logic [CAP_W-1:0]   capacity_reg;

  lrc_pkg::lrc_in_t  op_queue[$];
  lrc_pkg::lrc_out_t pending_results[$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int errors = 0;
  int results_seen = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int seg_kind = 0;
  int seg_left = 0;
  int pat_cnt = 0;

  lru_keyed_result_cache_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Move slot s to rank 0; slots that were more recent age by one
  function automatic void make_most_recent(int s);
    int old_rank;
    old_rank = slot_rank[s];
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && i != s && slot_rank[i] < old_rank) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endfunction

  // Apply one operation to the predicted cache and return its result
  function automatic lrc_pkg::lrc_out_t cache_apply(lrc_pkg::lrc_in_t op);
    lrc_pkg::lrc_out_t res;
    int match;
    int cap;
    int fill;
    int oldest;
    int free_slot;
    res = '0;
    match = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match < 0 && slot_valid[i] && slot_key[i] == op.key) match = i;
    end
    case (op.mode)
      lrc_pkg::MODE_LOOKUP: begin
        if (match >= 0) begin
          res.hit = 1'b1;
          res.data_out = slot_value[match];
          make_most_recent(match);
          if (hit_total != lrc_pkg::COUNT_MAX) hit_total++;
        end else if (miss_total != lrc_pkg::COUNT_MAX) begin
          miss_total++;
        end
      end
      lrc_pkg::MODE_STORE: begin
        if (match >= 0) begin
          slot_value[match] = op.value;
          make_most_recent(match);
        end else begin
          cap = (capacity_reg == 0) ? 1 : (capacity_reg > ENTRIES) ? ENTRIES : capacity_reg;
          fill = 0;
          oldest = -1;
          free_slot = -1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i]) begin
              fill++;
              if (oldest < 0 || slot_rank[i] > slot_rank[oldest]) oldest = i;
            end else if (free_slot < 0) begin
              free_slot = i;
            end
          end
          // Evict the least recently used slot once the cache is at capacity
          if (fill >= cap && oldest >= 0) begin
            slot_valid[oldest] = 1'b0;
            res.evicted = 1'b1;
            free_slot = oldest;
          end
          if (free_slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (slot_valid[i]) slot_rank[i]++;
            end
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot] = op.key;
            slot_value[free_slot] = op.value;
            slot_rank[free_slot] = 0;
          end
        end
      end
      lrc_pkg::MODE_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
        hit_total = '0;
        miss_total = '0;
      end
      default: ;
    endcase
    res.hit_count = hit_total;
    res.miss_count = miss_total;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, field, got, want);
    errors++;
  endtask

  task automatic add_op(logic [1:0] m, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
    lrc_pkg::lrc_in_t op;
    op.mode = m;
    op.key = k;
    op.value = v;
    op_queue.push_back(op);
  endtask

  function automatic lrc_pkg::lrc_in_t random_op(int pool_n);
    lrc_pkg::lrc_in_t op;
    int r;
    int rv;
    r = $urandom_range(0, 99);
    op.mode = (r < 50) ? lrc_pkg::MODE_LOOKUP : (r < 93) ? lrc_pkg::MODE_STORE :
              (r < 97) ? lrc_pkg::MODE_CLEAR : MODE_UNUSED;
    op.key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom) :
             key_pool[$urandom_range(0, pool_n - 1)];
    rv = $urandom_range(0, 15);
    op.value = (rv == 0) ? '0 : (rv == 1) ? '1 : VALUE_W'($urandom);
    return op;
  endfunction

  // Wait until every queued item has transferred and every result is back
  task automatic wait_idle();
    @(negedge clk);
    while (op_queue.size() != 0 || in_valid || pending_results.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    capacity_reg = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(logic [CAP_W-1:0] cap, int n_ops);
    int eff;
    int pool_n;
    int counted;
    lrc_pkg::lrc_in_t op;
    write_capacity(cap);
    eff = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
    pool_n = (eff + 4 > POOL_SIZE) ? POOL_SIZE : eff + 4;
    counted = 0;
    @(negedge clk);
    while (counted < n_ops) begin
      op = random_op(pool_n);
      op_queue.push_back(op);
      if (op.mode != MODE_UNUSED) counted++;
    end
  endtask

  // Input driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (in_valid && !in_stall) begin
      pending_results.push_back(cache_apply(in_data));
      if (burst_left > 1 && op_queue.size() != 0) begin
        in_data <= op_queue.pop_front();
        burst_left <= burst_left - 1;
      end else begin
        in_valid <= 1'b0;
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else if (!in_valid) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (op_queue.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= op_queue.pop_front();
        burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
    end
  end

  // Result stall: one long hold-off, otherwise segments of differing stall patterns
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 120) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      pat_cnt <= (pat_cnt == 4) ? 0 : pat_cnt + 1;
      if (seg_left == 0) begin
        seg_kind <= $urandom_range(0, 3);
        seg_left <= $urandom_range(32, 200);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (seg_kind)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 1);
        2: out_stall <= (pat_cnt < 3);
        default: out_stall <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Result monitor: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    lrc_pkg::lrc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result %0d with no operation outstanding", results_seen);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.hit !== want.hit)
          report_mismatch("hit", 32'(out_data.hit), 32'(want.hit));
        if (out_data.data_out !== want.data_out)
          report_mismatch("data_out", out_data.data_out, want.data_out);
        if (out_data.evicted !== want.evicted)
          report_mismatch("evicted", 32'(out_data.evicted), 32'(want.evicted));
        if (out_data.hit_count !== want.hit_count)
          report_mismatch("hit_count", 32'(out_data.hit_count), 32'(want.hit_count));
        if (out_data.miss_count !== want.miss_count)
          report_mismatch("miss_count", 32'(out_data.miss_count), 32'(want.miss_count));
      end
      results_seen <= results_seen + 1;
    end
  end

  // Stimulus and end of run
  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i] = '0;
      slot_value[i] = '0;
      slot_rank[i] = 0;
    end
    hit_total = '0;
    miss_total = '0;
    capacity_reg = lrc_pkg::CAP_RESET;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Basic lookup, store, overwrite, unused mode and clear at reset capacity
    @(negedge clk);
    add_op(lrc_pkg::MODE_LOOKUP, '0, '1);
    add_op(lrc_pkg::MODE_STORE, '0, '0);
    add_op(lrc_pkg::MODE_STORE, '1, '1);
    add_op(lrc_pkg::MODE_LOOKUP, '0, '0);
    add_op(lrc_pkg::MODE_LOOKUP, '1, '0);
    add_op(lrc_pkg::MODE_STORE, '0, 32'hA5A5_5A5A);
    add_op(lrc_pkg::MODE_LOOKUP, '0, '1);
    add_op(MODE_UNUSED, '1, '1);
    add_op(lrc_pkg::MODE_CLEAR, '1, '1);
    add_op(lrc_pkg::MODE_LOOKUP, '1, '0);

    // Eviction order at capacity two: a refreshed entry survives
    write_capacity(CAP_W'(2));
    @(negedge clk);
    add_op(lrc_pkg::MODE_STORE, 32'h1111_0001, 32'h0000_00AA);
    add_op(lrc_pkg::MODE_STORE, 32'h1111_0002, 32'h0000_00BB);
    add_op(lrc_pkg::MODE_LOOKUP, 32'h1111_0001, '0);
    add_op(lrc_pkg::MODE_STORE, 32'h1111_0003, 32'h0000_00CC);
    add_op(lrc_pkg::MODE_LOOKUP, 32'h1111_0002, '0);
    add_op(lrc_pkg::MODE_LOOKUP, 32'h1111_0001, '0);
    add_op(lrc_pkg::MODE_LOOKUP, 32'h1111_0003, '0);

    // Capacity zero acts as one
    write_capacity('0);
    @(negedge clk);
    add_op(lrc_pkg::MODE_STORE, 32'h2222_0004, 32'h1234_5678);
    add_op(lrc_pkg::MODE_STORE, 32'h2222_0005, 32'h8765_4321);
    add_op(lrc_pkg::MODE_LOOKUP, 32'h2222_0004, '0);

    // Random traffic; the 3 phase follows a full cache to shrink below the fill
    random_phase('1, 90);
    random_phase(CAP_W'(1), 90);
    random_phase(CAP_W'(8), 90);
    random_phase(CAP_W'(16), 90);
    random_phase(CAP_W'(3), 90);
    random_phase(CAP_W'(17), 90);
    random_phase(CAP_W'(5), 90);
    random_phase(CAP_W'(12), 90);
    random_phase(CAP_W'(16), 90);

    wait_idle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: lru_keyed_result_cache_unit.f
design/lrc_pkg.sv
design/lrc_scan.sv
design/lru_keyed_result_cache_unit.sv
design/lrc_checker.sv
bench/lru_keyed_result_cache_unit_tb.sv
